// File: hdl/gms_pkg.sv
// Shared types and constants for the glyph margin scanner.
// No dependencies; imported by the glyph store, the top level and the testbench.
package gms_pkg;

    localparam int GLYPHS_PER_ROW = 16;
    localparam int NUM_GLYPHS     = 256;
    localparam int IDX_W          = 8;
    localparam int MARGIN_W       = 10;

    // request kinds; the last one is not decoded and gives no result
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_INK_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_LEFT_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_RIGHT_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_FIXED_WIDTH   = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [1:0]       kind;
        logic [IDX_W-1:0] idx;
        logic             ink;
    } store_req_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] code;
        logic             has_ink;
    } store_rsp_t;

endpackage

// File: hdl/gms_glyph_store.sv
// Per-glyph ink store: ink flags in flops, column extents in a synchronous RAM.
// Read-modify-write with a registered read and write-to-read forwarding.
// Depends on gms_pkg.
module gms_glyph_store #(
    parameter int CELL_LOG2 = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  gms_pkg::store_req_t  req,
    input  logic [CELL_LOG2-1:0] req_col,
    output gms_pkg::store_rsp_t  rsp,
    output logic [CELL_LOG2-1:0] rsp_min,
    output logic [CELL_LOG2-1:0] rsp_max
);
    import gms_pkg::*;

    localparam int CW = CELL_LOG2;

    logic [2*CW-1:0]     ext_mem [NUM_GLYPHS];
    logic [NUM_GLYPHS-1:0] has_ink_reg;

    logic                p1_valid_reg;
    logic [1:0]          p1_kind_reg;
    logic [IDX_W-1:0]    p1_idx_reg;
    logic                p1_ink_reg;
    logic [CW-1:0]       p1_col_reg;
    logic [2*CW-1:0]     rd_data_reg;
    logic                fwd_hit_reg;
    logic [2*CW-1:0]     fwd_data_reg;

    logic [2*CW-1:0]     cur_data;
    logic [CW-1:0]       cur_min;
    logic [CW-1:0]       cur_max;
    logic                cur_has;
    logic                wr_en;
    logic                clr_en;
    logic [2*CW-1:0]     wr_data;

    assign cur_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign cur_min  = cur_data[2*CW-1:CW];
    assign cur_max  = cur_data[CW-1:0];
    assign cur_has  = has_ink_reg[p1_idx_reg];

    assign wr_en  = adv && p1_valid_reg && (p1_kind_reg == KIND_PIXEL) && p1_ink_reg;
    assign clr_en = adv && p1_valid_reg && (p1_kind_reg == KIND_CLEAR);

    always_comb begin
        if (cur_has) begin
            wr_data[2*CW-1:CW] = (p1_col_reg < cur_min) ? p1_col_reg : cur_min;
            wr_data[CW-1:0]    = (p1_col_reg > cur_max) ? p1_col_reg : cur_max;
        end else begin
            wr_data = {p1_col_reg, p1_col_reg};
        end
    end

    // extent RAM
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ext_mem[p1_idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && req.valid) begin
            rd_data_reg <= ext_mem[req.idx];
        end
    end

    // same-entry write in the read cycle: RAM returns old data, take the new
    always_ff @(posedge aclk) begin
        if (adv && req.valid) begin
            fwd_hit_reg  <= wr_en && (p1_idx_reg == req.idx);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_ink_reg <= '0;
        end else if (clr_en) begin
            has_ink_reg <= '0;
        end else if (wr_en) begin
            has_ink_reg[p1_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_kind_reg <= req.kind;
            p1_idx_reg  <= req.idx;
            p1_ink_reg  <= req.ink;
            p1_col_reg  <= req_col;
        end
    end

    assign rsp.valid   = p1_valid_reg && (p1_kind_reg == KIND_QUERY);
    assign rsp.code    = p1_idx_reg;
    assign rsp.has_ink = cur_has;
    assign rsp_min     = cur_min;
    assign rsp_max     = cur_max;

endmodule

// File: hdl/glyph_margin_scanner_top.sv
// Glyph margin scanner top level. A query result passes the store's p1 registers,
// the p2 registers and the output registers. Throughput is one request per cycle
// when not stalled, set by the single read-modify-write pass through the extent RAM
// (same-entry hazards are forwarded). The whole pipeline stalls while a result waits
// on m_ready. Reset (synchronous, active low) clears ink flags, pipeline valids and
// restores register defaults; the extent RAM needs no clearing pass.
module glyph_margin_scanner_top #(
    parameter int CELL_LOG2 = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [7:0]         s_pix_x,
    input  logic [7:0]         s_pix_y,
    input  logic [7:0]         s_red,
    input  logic [7:0]         s_green,
    input  logic [7:0]         s_blue,
    input  logic [7:0]         s_glyph_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_code_echo,
    output logic signed [10:0] m_left_margin_q4,
    output logic [9:0]         m_right_margin_q4,
    output logic signed [13:0] m_tex_x_q4,
    output logic [10:0]        m_width_q4,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data
);
    import gms_pkg::*;

    localparam int CW      = CELL_LOG2;
    localparam int CELL_Q4 = 16 << CELL_LOG2;
    localparam logic [9:0]  FIXED_RIGHT = (CELL_Q4 > 1023) ? 10'd1023 : 10'(CELL_Q4);
    localparam logic [10:0] FIXED_WIDTH = 11'(CELL_Q4);

    // configuration
    logic [7:0]          ink_threshold_reg;
    logic [9:0]          left_limit_reg;
    logic [9:0]          right_limit_reg;
    logic                fixed_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ink_threshold_reg <= 8'd64;
            left_limit_reg    <= 10'd115;
            right_limit_reg   <= 10'd141;
            fixed_width_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INK_THRESHOLD: ink_threshold_reg <= cfg_data[7:0];
                CFG_LEFT_LIMIT:    left_limit_reg    <= cfg_data;
                CFG_RIGHT_LIMIT:   right_limit_reg   <= cfg_data;
                CFG_FIXED_WIDTH:   fixed_width_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // request decode
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic        in_atlas;
    store_req_t  req;
    store_rsp_t  rsp;
    logic [CW-1:0] rsp_min;
    logic [CW-1:0] rsp_max;

    assign cell_x   = s_pix_x >> CELL_LOG2;
    assign cell_y   = s_pix_y >> CELL_LOG2;
    assign in_atlas = (cell_x < 8'(GLYPHS_PER_ROW)) && (cell_y < 8'(GLYPHS_PER_ROW));

    always_comb begin
        req.valid = s_valid && (s_kind != KIND_UNUSED);
        req.kind  = s_kind;
        req.ink   = in_atlas && (s_red > ink_threshold_reg)
                    && (s_green > ink_threshold_reg) && (s_blue > ink_threshold_reg);
        req.idx   = (s_kind == KIND_PIXEL) ? {cell_y[3:0], cell_x[3:0]} : s_glyph_code;
    end

    gms_glyph_store #(
        .CELL_LOG2(CELL_LOG2)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .req     (req),
        .req_col (s_pix_x[CW-1:0]),
        .rsp     (rsp),
        .rsp_min (rsp_min),
        .rsp_max (rsp_max)
    );

    // margins
    logic signed [10:0] left_raw;
    logic signed [10:0] left_lim;
    logic signed [10:0] left_sel;
    logic [10:0]        right_raw;
    logic [10:0]        right_max;
    logic [9:0]         right_sel;

    assign left_raw  = $signed((11'(rsp_min) - 11'd1) << 4);
    assign left_lim  = $signed({1'b0, left_limit_reg});
    assign right_raw = (11'(rsp_max) + 11'd1) << 4;

    always_comb begin
        if (fixed_width_reg) begin
            left_sel  = '0;
            right_max = 11'(FIXED_RIGHT);
        end else begin
            left_sel  = (rsp.has_ink && (left_raw < left_lim)) ? left_raw : left_lim;
            right_max = (rsp.has_ink && (right_raw > {1'b0, right_limit_reg}))
                        ? right_raw : {1'b0, right_limit_reg};
        end
        right_sel = right_max[10] ? 10'd1023 : right_max[9:0];
    end

    logic               p2_valid_reg;
    logic [7:0]         p2_code_reg;
    logic signed [10:0] p2_left_reg;
    logic [9:0]         p2_right_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= rsp.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_code_reg  <= rsp.code;
            p2_left_reg  <= left_sel;
            p2_right_reg <= right_sel;
        end
    end

    // width and texture offset
    logic signed [11:0] diff;
    logic [10:0]        width;
    logic [13:0]        origin;
    logic [13:0]        tex;

    assign diff   = $signed({2'b00, p2_right_reg}) - $signed({p2_left_reg[10], p2_left_reg});
    assign width  = fixed_width_reg ? FIXED_WIDTH : (diff[11] ? 11'd0 : diff[10:0]);
    assign origin = 14'(p2_code_reg[3:0]) << (CELL_LOG2 + 4);
    assign tex    = origin + {{3{p2_left_reg[10]}}, p2_left_reg};

    logic               m_valid_reg;
    logic [7:0]         m_code_reg;
    logic signed [10:0] m_left_reg;
    logic [9:0]         m_right_reg;
    logic signed [13:0] m_tex_reg;
    logic [10:0]        m_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p2_valid_reg) begin
            m_code_reg  <= p2_code_reg;
            m_left_reg  <= p2_left_reg;
            m_right_reg <= p2_right_reg;
            m_tex_reg   <= $signed(tex);
            m_width_reg <= width;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_code_echo       = m_code_reg;
    assign m_left_margin_q4  = m_left_reg;
    assign m_right_margin_q4 = m_right_reg;
    assign m_tex_x_q4        = m_tex_reg;
    assign m_width_q4        = m_width_reg;

endmodule

// File: hdl/gms_checker.sv
// Port-level checks for the glyph margin scanner, bound to the top level.
// Depends on glyph_margin_scanner_top's port list only.
module gms_checker #(
    parameter int CELL_LOG2 = 4
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [7:0]         m_code_echo,
    input logic signed [10:0] m_left_margin_q4,
    input logic [9:0]         m_right_margin_q4,
    input logic signed [13:0] m_tex_x_q4,
    input logic [10:0]        m_width_q4
);
    localparam int CELL_Q4 = 16 << CELL_LOG2;

    logic [13:0]        exp_tex;
    logic signed [11:0] exp_diff;

    assign exp_tex  = (14'(m_code_echo[3:0]) << (CELL_LOG2 + 4))
                      + {{3{m_left_margin_q4[10]}}, m_left_margin_q4};
    assign exp_diff = $signed({2'b00, m_right_margin_q4})
                      - $signed({m_left_margin_q4[10], m_left_margin_q4});

    // a stalled result request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_echo) && $stable(m_width_q4))
        else $error("result request changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_tex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($unsigned(m_tex_x_q4) == exp_tex))
        else $error("texture offset does not match cell origin plus left margin");

    a_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_width_q4 == 11'(CELL_Q4))
                 || (exp_diff < 0 && m_width_q4 == 11'd0)
                 || (exp_diff >= 0 && m_width_q4 == exp_diff[10:0]))
        else $error("width inconsistent with margins");

endmodule

bind glyph_margin_scanner_top gms_checker #(
    .CELL_LOG2(CELL_LOG2)
) u_gms_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_code_echo       (m_code_echo),
    .m_left_margin_q4  (m_left_margin_q4),
    .m_right_margin_q4 (m_right_margin_q4),
    .m_tex_x_q4        (m_tex_x_q4),
    .m_width_q4        (m_width_q4)
);

// File: verif/glyph_margin_scanner_top_test.sv
// Self-checking testbench for glyph_margin_scanner_top: pixel, clear and query requests with
// random flow control, a margin tracker that predicts every query result, field-by-field checks.
// Depends on gms_pkg and the glyph_margin_scanner_top RTL only.
`timescale 1ns / 1ps

module glyph_margin_scanner_top_test;
    import gms_pkg::*;

    localparam int CELL_LOG2     = 4;
    localparam int CELL_PIX      = 1 << CELL_LOG2;
    localparam int CELL_Q4       = CELL_PIX * 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 4000;
    localparam int FOCUS_COUNT   = 6;

    typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_TOGGLE} flow_style_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pix_x;
        logic [7:0] pix_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] glyph_code;
    } request_t;

    typedef struct packed {
        logic [7:0]  code;
        logic [10:0] left_q4;
        logic [9:0]  right_q4;
        logic [13:0] tex_q4;
        logic [10:0] width_q4;
    } margin_t;

    class margin_tracker;
        bit                   inked[NUM_GLYPHS];
        logic [CELL_LOG2-1:0] lo_col[NUM_GLYPHS];
        logic [CELL_LOG2-1:0] hi_col[NUM_GLYPHS];
        logic [7:0]           threshold;
        logic [9:0]           left_cap;
        logic [9:0]           right_floor;
        bit                   whole_cell;
        margin_t              due_margins[$];
        int faults, compared, pixels, inked_pixels, queries, clears, ignored;

        function new();
            threshold   = 8'd64;
            left_cap    = 10'd115;
            right_floor = 10'd141;
            whole_cell  = 1'b0;
            foreach (inked[i]) inked[i] = 1'b0;
        endfunction

        function void set_register(logic [1:0] index, logic [9:0] data);
            case (index)
                CFG_INK_THRESHOLD: threshold   = data[7:0];
                CFG_LEFT_LIMIT:    left_cap    = data;
                CFG_RIGHT_LIMIT:   right_floor = data;
                CFG_FIXED_WIDTH:   whole_cell  = data[0];
                default: ;
            endcase
        endfunction

        function void note_request(request_t rq);
            margin_t want;
            int cx, cy, col, idx, code, origin, lo, hi, cap, floor_q4;
            int left, right, width, tex;
            case (rq.kind)
                KIND_CLEAR: begin
                    clears++;
                    foreach (inked[i]) inked[i] = 1'b0;
                end
                KIND_PIXEL: begin
                    pixels++;
                    cx  = rq.pix_x >> CELL_LOG2;
                    cy  = rq.pix_y >> CELL_LOG2;
                    col = rq.pix_x % CELL_PIX;
                    if (cx < GLYPHS_PER_ROW && cy < GLYPHS_PER_ROW && rq.red > threshold
                            && rq.green > threshold && rq.blue > threshold) begin
                        inked_pixels++;
                        idx = (cy * GLYPHS_PER_ROW + cx) % NUM_GLYPHS;
                        if (!inked[idx]) begin
                            inked[idx]  = 1'b1;
                            lo_col[idx] = CELL_LOG2'(col);
                            hi_col[idx] = CELL_LOG2'(col);
                        end else begin
                            if (col < lo_col[idx]) lo_col[idx] = CELL_LOG2'(col);
                            if (col > hi_col[idx]) hi_col[idx] = CELL_LOG2'(col);
                        end
                    end
                end
                KIND_QUERY: begin
                    queries++;
                    code   = rq.glyph_code;
                    origin = (code % GLYPHS_PER_ROW) * CELL_Q4;
                    if (whole_cell) begin
                        left  = 0;
                        right = (CELL_Q4 > 1023) ? 1023 : CELL_Q4;
                        width = CELL_Q4;
                    end else begin
                        cap      = left_cap;
                        floor_q4 = right_floor;
                        if (inked[code]) begin
                            lo    = lo_col[code];
                            hi    = hi_col[code];
                            left  = (lo - 1) * 16;
                            right = (hi + 1) * 16;
                        end else begin
                            left  = cap;
                            right = floor_q4;
                        end
                        if (left > cap) left = cap;
                        if (right < floor_q4) right = floor_q4;
                        if (right > 1023) right = 1023;
                        width = right - left;
                        if (width < 0) width = 0;
                    end
                    tex           = origin + left;
                    want.code     = rq.glyph_code;
                    want.left_q4  = left[10:0];
                    want.right_q4 = right[9:0];
                    want.tex_q4   = tex[13:0];
                    want.width_q4 = width[10:0];
                    due_margins.push_back(want);
                end
                default: ignored++;
            endcase
        endfunction

        function void compare_field(string field, logic [7:0] code,
                                    logic signed [31:0] want, logic signed [31:0] got);
            if (got !== want) begin
                faults++;
                if (faults <= 10)
                    $display("glyph %0d %s: expected %0d, got %0d", code, field, want, got);
            end
        endfunction

        function void check_result(margin_t got);
            margin_t want;
            if (due_margins.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("result for glyph %0d with no query outstanding", got.code);
                return;
            end
            want = due_margins.pop_front();
            compared++;
            compare_field("code echo", want.code, want.code, got.code);
            compare_field("left margin", want.code, $signed(want.left_q4), $signed(got.left_q4));
            compare_field("right margin", want.code, want.right_q4, got.right_q4);
            compare_field("texture x", want.code, $signed(want.tex_q4), $signed(got.tex_q4));
            compare_field("width", want.code, want.width_q4, got.width_q4);
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [7:0]         s_pix_x;
    logic [7:0]         s_pix_y;
    logic [7:0]         s_red;
    logic [7:0]         s_green;
    logic [7:0]         s_blue;
    logic [7:0]         s_glyph_code;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_code_echo;
    logic signed [10:0] m_left_margin_q4;
    logic [9:0]         m_right_margin_q4;
    logic signed [13:0] m_tex_x_q4;
    logic [10:0]        m_width_q4;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [9:0]         cfg_data;

    margin_tracker tracker;
    logic [7:0]    focus_glyphs[FOCUS_COUNT];
    int            burst_left;
    int            settings_applied;
    int            quiet_cycles;
    event          hold_go;
    bit            hold_active;
    flow_style_t   flow_style = FLOW_FREE;
    int            flow_span;

    glyph_margin_scanner_top #(.CELL_LOG2(CELL_LOG2)) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_pix_x           (s_pix_x),
        .s_pix_y           (s_pix_y),
        .s_red             (s_red),
        .s_green           (s_green),
        .s_blue            (s_blue),
        .s_glyph_code      (s_glyph_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_code_echo       (m_code_echo),
        .m_left_margin_q4  (m_left_margin_q4),
        .m_right_margin_q4 (m_right_margin_q4),
        .m_tex_x_q4        (m_tex_x_q4),
        .m_width_q4        (m_width_q4),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #10 aclk = ~aclk;

    // long receiver hold-off, counted here so the sender keeps running meanwhile
    always begin
        @(hold_go);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_active = 1'b0;
    end

    // receiver back-pressure: a new style is drawn at random whenever the current span runs out
    always @(negedge aclk) begin
        if (flow_span == 0) begin
            flow_span  = $urandom_range(20, 80);
            flow_style = flow_style_t'($urandom_range(0, 3));
        end
        flow_span--;
        if (hold_active)
            m_ready <= 1'b0;
        else begin
            case (flow_style)
                FLOW_FREE:   m_ready <= 1'b1;
                FLOW_COIN:   m_ready <= 1'($urandom_range(0, 1));
                FLOW_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:     m_ready <= ~m_ready;
            endcase
        end
    end

    always @(posedge aclk) begin : result_monitor
        margin_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.code     = m_code_echo;
            seen.left_q4  = m_left_margin_q4;
            seen.right_q4 = m_right_margin_q4;
            seen.tex_q4   = m_tex_x_q4;
            seen.width_q4 = m_width_q4;
            tracker.check_result(seen);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, tracker.due_margins.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic request_t pixel_req(logic [7:0] x, logic [7:0] y,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
        request_t rq;
        rq            = '0;
        rq.kind       = KIND_PIXEL;
        rq.pix_x      = x;
        rq.pix_y      = y;
        rq.red        = r;
        rq.green      = g;
        rq.blue       = b;
        return rq;
    endfunction

    function automatic request_t query_req(logic [7:0] code);
        request_t rq;
        rq            = '0;
        rq.kind       = KIND_QUERY;
        rq.glyph_code = code;
        return rq;
    endfunction

    function automatic request_t plain_req(logic [1:0] kind);
        request_t rq;
        rq      = '0;
        rq.kind = kind;
        return rq;
    endfunction

    function automatic logic [7:0] above(logic [7:0] thr);
        if (thr == 8'd255) return 8'd255;
        return 8'($urandom_range(255, int'(thr) + 1));
    endfunction

    // mostly pixels and queries aimed at a few glyphs, so extents build up and get read back
    function automatic request_t random_request();
        request_t   rq;
        int         pick;
        logic [7:0] g;
        logic [7:0] thr;
        rq.pix_x      = 8'($urandom);
        rq.pix_y      = 8'($urandom);
        rq.red        = 8'($urandom);
        rq.green      = 8'($urandom);
        rq.blue       = 8'($urandom);
        rq.glyph_code = 8'($urandom);
        thr           = tracker.threshold;
        g             = focus_glyphs[$urandom_range(0, FOCUS_COUNT - 1)];
        pick          = $urandom_range(0, 99);
        if (pick < 2)
            rq.kind = KIND_CLEAR;
        else if (pick < 5)
            rq.kind = KIND_UNUSED;
        else if (pick < 30) begin
            rq.kind = KIND_QUERY;
            if ($urandom_range(0, 9) < 7) rq.glyph_code = g;
        end else begin
            rq.kind = KIND_PIXEL;
            if ($urandom_range(0, 3) != 0) begin
                rq.pix_x = 8'((g % GLYPHS_PER_ROW) * CELL_PIX
                              + $urandom_range(0, CELL_PIX - 1));
                rq.pix_y = 8'((g / GLYPHS_PER_ROW) * CELL_PIX
                              + $urandom_range(0, CELL_PIX - 1));
            end
            case ($urandom_range(0, 3))
                0: ;
                3: begin
                    rq.red   = above(thr);
                    rq.green = above(thr);
                    rq.blue  = above(thr);
                    case ($urandom_range(0, 2))
                        0: rq.red   = thr;
                        1: rq.green = thr;
                        default: rq.blue = thr;
                    endcase
                end
                default: begin
                    rq.red   = above(thr);
                    rq.green = above(thr);
                    rq.blue  = above(thr);
                end
            endcase
        end
        return rq;
    endfunction

    task automatic send_request(request_t rq, int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_kind       <= rq.kind;
        s_pix_x      <= rq.pix_x;
        s_pix_y      <= rq.pix_y;
        s_red        <= rq.red;
        s_green      <= rq.green;
        s_blue       <= rq.blue;
        s_glyph_code <= rq.glyph_code;
        s_valid      <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(rq);
    endtask

    // stop sending and wait for every outstanding result, plus pipeline slack
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.due_margins.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [1:0] index, logic [9:0] data);
        @(negedge aclk);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.set_register(index, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [7:0] thr, logic [9:0] left_cap,
                                 logic [9:0] right_floor, logic whole_cell);
        drain();
        write_register(CFG_INK_THRESHOLD, {2'b00, thr});
        write_register(CFG_LEFT_LIMIT, left_cap);
        write_register(CFG_RIGHT_LIMIT, right_floor);
        write_register(CFG_FIXED_WIDTH, {9'd0, whole_cell});
        foreach (focus_glyphs[i]) focus_glyphs[i] = 8'($urandom);
        settings_applied++;
    endtask

    task automatic run_random(int count, int hold_at, int pause_at);
        int gap;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) -> hold_go;
            if (n == pause_at) drain();
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 8);
            end
            burst_left--;
            send_request(random_request(), gap);
        end
    endtask

    task automatic directed_requests();
        send_request(query_req(8'd0), 0);                      // glyph with no ink
        send_request(pixel_req(8'd0, 8'd0, 8'd255, 8'd255, 8'd255), 0);
        send_request(pixel_req(8'd15, 8'd3, 8'd255, 8'd255, 8'd255), 1);
        send_request(query_req(8'd0), 0);                      // full span, negative left
        send_request(pixel_req(8'd21, 8'd0, 8'd255, 8'd64, 8'd255), 0);
        send_request(pixel_req(8'd22, 8'd1, 8'd64, 8'd255, 8'd255), 2);
        send_request(pixel_req(8'd22, 8'd1, 8'd0, 8'd0, 8'd0), 0);
        send_request(query_req(8'd1), 0);                      // channels at threshold: no ink
        send_request(pixel_req(8'd255, 8'd255, 8'd65, 8'd65, 8'd65), 0);
        send_request(query_req(8'd255), 1);
        send_request(pixel_req(8'd23, 8'd18, 8'd200, 8'd201, 8'd202), 0);
        send_request(pixel_req(8'd25, 8'd31, 8'd255, 8'd255, 8'd255), 0);
        send_request(query_req(8'd17), 0);                     // right edge past the limit
        send_request(plain_req(KIND_UNUSED), 0);
        send_request(plain_req(KIND_CLEAR), 0);
        send_request(query_req(8'd0), 0);                      // cleared glyph
        send_request(pixel_req(8'd8, 8'd15, 8'd255, 8'd255, 8'd255), 0);
        send_request(query_req(8'd0), 2);                      // stale extents overwritten
        send_request(query_req(8'hAA), 0);
        send_request(query_req(8'h55), 0);
        send_request(query_req(8'd255), 0);
    endtask

    initial begin
        tracker      = new();
        s_valid      = 1'b0;
        s_kind       = KIND_CLEAR;
        s_pix_x      = '0;
        s_pix_y      = '0;
        s_red        = '0;
        s_green      = '0;
        s_blue       = '0;
        s_glyph_code = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_INK_THRESHOLD;
        cfg_data     = '0;
        foreach (focus_glyphs[i]) focus_glyphs[i] = 8'($urandom);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed_requests();
        run_random(75, -1, -1);
        apply_setting(8'd0, 10'd0, 10'd0, 1'b0);
        run_random(75, 30, -1);
        apply_setting(8'd255, 10'd1023, 10'd1023, 1'b1);
        run_random(60, -1, -1);
        apply_setting(8'd200, 10'd1023, 10'd0, 1'b0);
        run_random(75, -1, 40);
        apply_setting(8'($urandom), 10'($urandom), 10'($urandom), 1'b0);
        run_random(75, 50, -1);
        apply_setting(8'($urandom), 10'($urandom), 10'($urandom), 1'b0);
        run_random(90, -1, -1);
        drain();

        $display("Covered %0d pixels (%0d inked), %0d queries, %0d clears, %0d ignored requests",
                 tracker.pixels, tracker.inked_pixels, tracker.queries, tracker.clears,
                 tracker.ignored);
        $display("%0d results compared over %0d register settings, %0d failures",
                 tracker.compared, settings_applied + 1,
                 tracker.faults + tracker.due_margins.size());
        if (tracker.faults == 0 && tracker.due_margins.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
